### sv/fmti_pkg.sv
// Package for the Fourier-mode table interpolator: word types, opcodes and fixed-point constants.
`default_nettype none

package fmti_pkg;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         mode_index;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [31:0] write_value;
    logic [15:0]        sun_cosine;
    logic [15:0]        view_cosine;
    logic [15:0]        azimuth_turns;
    logic               use_ocean;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_kind;
  } out_word_t;

  localparam logic [2:0] OP_NODE_WR  = 3'd0;
  localparam logic [2:0] OP_SKY_WR   = 3'd1;
  localparam logic [2:0] OP_OCEAN_WR = 3'd2;
  localparam logic [2:0] OP_TRANS_WR = 3'd3;
  localparam logic [2:0] OP_REFL_Q   = 3'd4;
  localparam logic [2:0] OP_TRANS_Q  = 3'd5;

  localparam logic        KIND_REFL  = 1'b0;
  localparam logic        KIND_TRANS = 1'b1;

  localparam logic signed [31:0] Q24_ONE  = 32'sd16777216;
  localparam logic [16:0]        FRAC_ONE = 17'd65536;
  localparam logic signed [17:0] W0       = 18'sd32768;

endpackage

`default_nettype wire

### sv/fourier_mode_table_interpolator.sv
// Top level of the Fourier-mode reflection table interpolator.
//
//  channel  | direction | handshake           | word
//  query    | in        | query_valid / stall | fmti_pkg::in_word_t
//  answer   | out       | answer_valid / stall| fmti_pkg::out_word_t
//  cfg      | in        | cfg_valid / ready   | layer_present bit
//
// Writes go straight into the stores. With the layer present a query reads the end nodes, then
// per axis clamps the cosine, checks the nodes one by one, divides for the fraction and stores
// the cell; a reflectance then reads the cosine ROM and, per mode, reads the table, interpolates
// and accumulates before it rounds, while a transmission (view axis only) reads and interpolates.
// Reset (rst, synchronous) clears the sequencer, answer_valid and layer_present; stores need
// no clearing. A new query waits for idle; a finished answer may wait in the output register.
`default_nettype none

module fourier_mode_table_interpolator #(
  parameter int NODE_COUNT    = 32,
  parameter int MODE_COUNT    = 3,
  parameter int COS_ROM_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 query_valid,
  output logic                      query_stall,
  input  wire fmti_pkg::in_word_t   query,
  output logic                      answer_valid,
  input  wire logic                 answer_stall,
  output fmti_pkg::out_word_t       answer,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);

  import fmti_pkg::*;

  localparam int NW     = $clog2(NODE_COUNT);
  localparam int TDEPTH = MODE_COUNT * NODE_COUNT * NODE_COUNT;
  localparam int TAW    = $clog2(2 * TDEPTH);
  localparam int VAW    = NW + 1;
  localparam int RAW    = $clog2(COS_ROM_DEPTH);

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_ENDS    = 13'h0002,
    S_CLAMP   = 13'h0004,
    S_SCAN_RD = 13'h0008,
    S_SCAN_CK = 13'h0010,
    S_DIV     = 13'h0020,
    S_LOC_END = 13'h0040,
    S_COS     = 13'h0080,
    S_TRD     = 13'h0100,
    S_LERP    = 13'h0200,
    S_ACC     = 13'h0400,
    S_FIN     = 13'h0800,
    S_DONE    = 13'h1000
  } state_t;

  function automatic logic [TAW-1:0] tab_index(input logic oc, input logic [1:0] m,
                                               input logic [NW-1:0] v,
                                               input logic [NW-1:0] s);
    return TAW'(oc ? TDEPTH : 0) + TAW'(m) * TAW'(NODE_COUNT * NODE_COUNT)
           + TAW'(v) * TAW'(NODE_COUNT) + TAW'(s);
  endfunction

  state_t             state;
  logic [2:0]         cnt;
  logic               axis;
  logic [1:0]         mode;
  logic               op_trans;
  logic               ocean;
  logic [15:0]        sun;
  logic [15:0]        view;
  logic [15:0]        turns;
  logic [15:0]        lo;
  logic [15:0]        hi;
  logic [15:0]        mu;
  logic [15:0]        node_lo;
  logic [16:0]        den;
  logic [16:0]        div_rem;
  logic [15:0]        quo;
  logic [3:0]         dcnt;
  logic [NW-1:0]      idx;
  logic [16:0]        frac;
  logic [NW-1:0]      cell_v;
  logic [NW-1:0]      cell_s;
  logic [16:0]        frac_v;
  logic [16:0]        frac_s;
  logic signed [17:0] w1;
  logic signed [17:0] w2;
  logic signed [31:0] corner [4];
  logic signed [31:0] lerp_a;
  logic signed [49:0] prod;
  logic signed [51:0] acc;
  logic signed [31:0] res_value;
  logic               res_kind;
  logic               layer_present;

  logic               accept;
  logic               row_ok;
  logic               tab_we;
  logic [TAW-1:0]     tab_waddr;
  logic [TAW-1:0]     tab_raddr;
  logic signed [31:0] tab_rdata;
  logic               vec_we;
  logic [VAW-1:0]     vec_waddr;
  logic signed [31:0] vec_wdata;
  logic [VAW-1:0]     vec_raddr;
  logic signed [31:0] vec_rdata;
  logic [RAW-1:0]     rom_addr;
  logic signed [16:0] rom_data;
  logic [15:0]        turns2;
  logic signed [31:0] lp;
  logic signed [31:0] lq;
  logic [16:0]        lf;
  logic signed [31:0] lerp_res;
  logic signed [17:0] wsel;
  logic [15:0]        mu_sel;
  logic [15:0]        mu_hi;
  logic [15:0]        mu_clamp;
  logic [15:0]        node_d;
  logic               scan_more;
  logic signed [16:0] num;
  logic signed [16:0] span;
  logic [17:0]        r2;
  logic               ge;
  logic [17:0]        rnext;
  logic signed [31:0] rd;
  logic signed [51:0] rnd;

  assign accept      = query_valid && !query_stall;
  assign query_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;

  // Store writes are taken straight from an accepted word.
  always_comb begin
    row_ok    = int'(query.row_index) < NODE_COUNT;
    tab_we    = accept && ((query.opcode == OP_SKY_WR) || (query.opcode == OP_OCEAN_WR))
                && (int'(query.mode_index) < MODE_COUNT) && row_ok
                && (int'(query.col_index) < NODE_COUNT);
    tab_waddr = tab_index(query.opcode == OP_OCEAN_WR, query.mode_index,
                          NW'(query.row_index), NW'(query.col_index));
    vec_we    = accept && ((query.opcode == OP_NODE_WR) || (query.opcode == OP_TRANS_WR))
                && row_ok;
    vec_waddr = {query.opcode == OP_TRANS_WR, NW'(query.row_index)};
    vec_wdata = (query.opcode == OP_NODE_WR) ? $signed({16'd0, query.write_value[15:0]})
                                             : query.write_value;
  end

  // Read addresses follow the sequencer step.
  always_comb begin
    vec_raddr = '0;
    tab_raddr = tab_index(ocean, mode, NW'(cell_v + NW'(cnt[0])), NW'(cell_s + NW'(cnt[1])));
    turns2    = {turns[14:0], 1'b0};
    if (cnt == 3'd0) begin
      rom_addr = RAW'((32'(turns) * 32'(COS_ROM_DEPTH)) >> 16);
    end else begin
      rom_addr = RAW'((32'(turns2) * 32'(COS_ROM_DEPTH)) >> 16);
    end
    case (state)
      S_ENDS: begin
        vec_raddr = (cnt == 3'd0) ? VAW'(0) : {1'b0, NW'(NODE_COUNT - 1)};
      end
      S_SCAN_RD: begin
        vec_raddr = {1'b0, NW'(idx + NW'(1))};
      end
      S_TRD: begin
        vec_raddr = (cnt == 3'd0) ? {1'b1, cell_v} : {1'b1, NW'(cell_v + NW'(1))};
      end
      default: begin
        vec_raddr = '0;
      end
    endcase
  end

  // Interpolator operands: two passes along the view axis, then one along the sun axis.
  always_comb begin
    case (cnt)
      3'd0: begin
        lp = corner[0];
        lq = corner[1];
        lf = frac_v;
      end
      3'd1: begin
        lp = corner[2];
        lq = corner[3];
        lf = frac_v;
      end
      default: begin
        lp = lerp_a;
        lq = lerp_res;
        lf = frac_s;
      end
    endcase
    case (mode)
      2'd0:    wsel = W0;
      2'd1:    wsel = w1;
      default: wsel = w2;
    endcase
  end

  always_comb begin
    mu_sel    = axis ? sun : view;
    mu_hi     = (mu_sel > hi) ? hi : mu_sel;
    mu_clamp  = (mu_hi < lo) ? lo : mu_hi;
    node_d    = vec_rdata[15:0];
    scan_more = (int'(idx) < NODE_COUNT - 2) && (node_d < mu);
    num       = $signed({1'b0, mu}) - $signed({1'b0, node_lo});
    span      = $signed({1'b0, node_d}) - $signed({1'b0, node_lo});
    r2        = {div_rem, 1'b0};
    ge        = r2 >= {1'b0, den};
    rnext     = ge ? (r2 - {1'b0, den}) : r2;
    rd        = op_trans ? vec_rdata : tab_rdata;
    rnd       = (acc + 52'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && ((query.opcode == OP_REFL_Q) || (query.opcode == OP_TRANS_Q))) begin
            ocean    <= query.use_ocean;
            sun      <= query.sun_cosine;
            view     <= query.view_cosine;
            turns    <= query.azimuth_turns;
            op_trans <= (query.opcode == OP_TRANS_Q);
            acc      <= '0;
            axis     <= 1'b0;
            mode     <= '0;
            cnt      <= '0;
            if (!layer_present) begin
              res_value <= (query.opcode == OP_TRANS_Q) ? Q24_ONE : 32'sd0;
              res_kind  <= (query.opcode == OP_TRANS_Q) ? KIND_TRANS : KIND_REFL;
              state     <= S_DONE;
            end else begin
              state <= S_ENDS;
            end
          end
        end
        S_ENDS: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            lo <= node_d;
          end
          if (cnt == 3'd2) begin
            hi    <= node_d;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          mu      <= mu_clamp;
          idx     <= '0;
          node_lo <= lo;
          state   <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CK;
        end
        S_SCAN_CK: begin
          if (scan_more) begin
            node_lo <= node_d;
            idx     <= NW'(idx + NW'(1));
            state   <= S_SCAN_RD;
          end else begin
            den     <= 17'(span);
            div_rem <= 17'(num);
            quo     <= '0;
            dcnt    <= '0;
            if ((num <= 17'sd0) || (span <= 17'sd0)) begin
              frac  <= '0;
              state <= S_LOC_END;
            end else if (num >= span) begin
              frac  <= FRAC_ONE;
              state <= S_LOC_END;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // One quotient bit per cycle; the remainder stays below the span.
          div_rem <= rnext[16:0];
          quo     <= {quo[14:0], ge};
          dcnt    <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            frac  <= {1'b0, quo[14:0], ge};
            state <= S_LOC_END;
          end
        end
        S_LOC_END: begin
          if (!axis) begin
            cell_v <= idx;
            frac_v <= frac;
          end else begin
            cell_s <= idx;
            frac_s <= frac;
          end
          cnt <= '0;
          if (op_trans) begin
            state <= S_TRD;
          end else if (!axis) begin
            axis  <= 1'b1;
            state <= S_CLAMP;
          end else begin
            state <= S_COS;
          end
        end
        S_COS: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            w1 <= {rom_data, 1'b0};
          end
          if (cnt == 3'd2) begin
            w2    <= {rom_data, 1'b0};
            cnt   <= '0;
            state <= S_TRD;
          end
        end
        S_TRD: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            corner[2'(cnt - 3'd1)] <= rd;
          end
          if ((op_trans && (cnt == 3'd2)) || (cnt == 3'd4)) begin
            cnt   <= '0;
            state <= S_LERP;
          end
        end
        S_LERP: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) begin
            if (op_trans) begin
              res_value <= lerp_res;
              res_kind  <= KIND_TRANS;
              state     <= S_DONE;
            end else begin
              lerp_a <= lerp_res;
            end
          end
          if (cnt == 3'd5) begin
            prod  <= wsel * lerp_res;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc <= acc + 52'(prod);
          cnt <= '0;
          if (int'(mode) == MODE_COUNT - 1) begin
            state <= S_FIN;
          end else begin
            mode  <= mode + 2'd1;
            state <= S_TRD;
          end
        end
        S_FIN: begin
          res_kind <= KIND_REFL;
          if (acc <= 52'sd0) begin
            res_value <= 32'sd0;
          end else if (rnd > 52'sh7fffffff) begin
            res_value <= 32'sh7fffffff;
          end else begin
            res_value <= rnd[31:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!answer_valid || !answer_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_valid <= 1'b0;
    end else if ((state == S_DONE) && (!answer_valid || !answer_stall)) begin
      answer_valid        <= 1'b1;
      answer.result_value <= res_value;
      answer.result_kind  <= res_kind;
    end else if (!answer_stall) begin
      answer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_present <= 1'b0;
    end else if (cfg_valid) begin
      layer_present <= cfg_data;
    end
  end

  fmti_store #(
    .TAW(TAW),
    .VAW(VAW)
  ) u_store (
    .clk      (clk),
    .tab_we   (tab_we),
    .tab_waddr(tab_waddr),
    .tab_wdata(query.write_value),
    .tab_raddr(tab_raddr),
    .tab_rdata(tab_rdata),
    .vec_we   (vec_we),
    .vec_waddr(vec_waddr),
    .vec_wdata(vec_wdata),
    .vec_raddr(vec_raddr),
    .vec_rdata(vec_rdata)
  );

  fmti_cos_rom #(
    .DEPTH(COS_ROM_DEPTH)
  ) u_cos_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  fmti_lerp u_lerp (
    .clk(clk),
    .p  (lp),
    .q  (lq),
    .f  (lf),
    .res(lerp_res)
  );

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOC_END) |-> (frac <= FRAC_ONE))
    else $error("cell fraction above one");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CK) |-> (int'(idx) <= NODE_COUNT - 2))
    else $error("node scan ran past the last cell");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < den))
    else $error("divider remainder not below span");

  a_refl_sign: assert property (@(posedge clk) disable iff (rst)
    (answer_valid && (answer.result_kind == KIND_REFL)) |-> !answer.result_value[31])
    else $error("negative reflectance answer");

endmodule

`default_nettype wire

### sv/fmti_store.sv
// Table and vector memories of the interpolator, one write and one registered read port each.
`default_nettype none

module fmti_store #(
  parameter int TAW = 12,
  parameter int VAW = 6
) (
  input  wire logic                  clk,
  input  wire logic                  tab_we,
  input  wire logic [TAW-1:0]        tab_waddr,
  input  wire logic signed [31:0]    tab_wdata,
  input  wire logic [TAW-1:0]        tab_raddr,
  output logic signed [31:0]         tab_rdata,
  input  wire logic                  vec_we,
  input  wire logic [VAW-1:0]        vec_waddr,
  input  wire logic signed [31:0]    vec_wdata,
  input  wire logic [VAW-1:0]        vec_raddr,
  output logic signed [31:0]         vec_rdata
);

  // Sky entries sit at the bottom of the table memory, ocean entries directly above them.
  logic signed [31:0] tab_mem [2**TAW];
  // Node cosines in the lower half, transmission values in the upper half.
  logic signed [31:0] vec_mem [2**VAW];

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rdata <= vec_mem[vec_raddr];
  end

endmodule

`default_nettype wire

### sv/fmti_cos_rom.sv
// Cosine ROM over one full turn with a registered read.
`default_nettype none

module fmti_cos_rom #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  output logic signed [16:0]            data
);

  localparam real PI   = 3.14159265358979323846;
  localparam real STEP = 2.0 * PI / real'(DEPTH);

  typedef logic signed [16:0] rom_t [DEPTH];

  function automatic rom_t build_table();
    rom_t t;
    real  v;
    for (int k = 0; k < DEPTH; k++) begin
      v = 32768.0 * $cos(STEP * real'(k));
      if (v >= 0.0) begin
        t[k] = 17'($rtoi(v + 0.5));
      end else begin
        t[k] = -17'($rtoi(0.5 - v));
      end
    end
    return t;
  endfunction

  localparam rom_t TABLE = build_table();

  always_ff @(posedge clk) begin
    data <= TABLE[addr];
  end

endmodule

`default_nettype wire

### sv/fmti_lerp.sv
// Two-stage linear interpolation p*(1-f) + q*f with rounding to Q8.24, half away from zero.
`default_nettype none

module fmti_lerp (
  input  wire logic               clk,
  input  wire logic signed [31:0] p,
  input  wire logic signed [31:0] q,
  input  wire logic [16:0]        f,
  output logic signed [31:0]      res
);

  logic [16:0]        inv;
  logic signed [49:0] pp;
  logic signed [49:0] qq;
  logic signed [50:0] total;
  logic [50:0]        mag;
  logic [50:0]        rmag;

  assign inv = 17'(17'd65536 - f);

  always_ff @(posedge clk) begin
    pp <= p * $signed({1'b0, inv});
    qq <= q * $signed({1'b0, f});
  end

  always_comb begin
    total = 51'(pp) + 51'(qq);
    mag   = total[50] ? 51'(-total) : 51'(total);
    rmag  = (mag + 51'd32768) >> 16;
  end

  always_ff @(posedge clk) begin
    res <= total[50] ? -32'(rmag) : 32'(rmag);
  end

endmodule

`default_nettype wire

### sim/tb_fourier_mode_table_interpolator.sv
// Self-checking testbench for the Fourier-mode table interpolator with a built-in predictor.
module tb_fourier_mode_table_interpolator;
  import fmti_pkg::*;

  localparam int NODES = 32;
  localparam int MODES = 3;
  localparam int ROM_DEPTH = 1024;
  localparam int SETTLE_CYCLES = 800;
  localparam int RANDOM_ITEMS = 1200;
  // Nodes from LIVE upward all sit at the top cosine, so every cell search ends below LIVE.
  localparam int LIVE = 6;

  logic clk;
  logic rst;
  logic query_valid;
  logic query_stall;
  in_word_t query;
  logic answer_valid;
  logic answer_stall;
  out_word_t answer;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  fourier_mode_table_interpolator u_dut (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .answer_valid(answer_valid), .answer_stall(answer_stall), .answer(answer),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state.
  int cos_table [ROM_DEPTH];
  logic [15:0] node_cos [NODES];
  logic signed [31:0] sky_tab [MODES][NODES][NODES];
  logic signed [31:0] ocean_tab [MODES][NODES][NODES];
  logic signed [31:0] trans_vec [NODES];
  logic layer_on;

  out_word_t expected_answers [$];
  int error_count;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Cosine ROM from a Taylor series in Q62, matching the block's table.
  function automatic void build_cosines();
    logic [63:0] d, q, rem, n, x, x2, sum, term, v;
    logic [63:0] pi_q62;
    bit neg;
    pi_q62 = 64'hC90FDAA22168C234;
    d = ROM_DEPTH;
    q = pi_q62 / (2 * d);
    rem = pi_q62 % (2 * d);
    for (int k = 0; k < ROM_DEPTH; k++) begin
      n = 4 * k;
      neg = 0;
      sum = 64'h4000000000000000;
      term = sum;
      if (n > 2 * d) n = 4 * d - n;
      if (n > d) begin
        neg = 1;
        n = 2 * d - n;
      end
      x = q * n + (rem * n) / (2 * d);
      x2 = mul_q62(x, x);
      for (int j = 1; j <= 14; j++) begin
        term = mul_q62(term, x2) / ((2 * j - 1) * (2 * j));
        if (j % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum[63]) sum = 0;
      v = (sum + (64'd1 << 46)) >> 47;
      cos_table[k] = neg ? -int'(v) : int'(v);
    end
  endfunction

  function automatic longint round16(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic longint blend(longint p, longint r, int f);
    return round16(p * (65536 - f) + r * f);
  endfunction

  function automatic void find_cell(int mu, output int cell_idx, output int frac);
    int lo, hi, num, den, i;
    lo = node_cos[0];
    hi = node_cos[NODES - 1];
    i = 0;
    if (mu > hi) mu = hi;
    if (mu < lo) mu = lo;
    while (i < NODES - 2 && int'(node_cos[i + 1]) < mu) i++;
    num = mu - int'(node_cos[i]);
    den = int'(node_cos[i + 1]) - int'(node_cos[i]);
    cell_idx = i;
    if (num <= 0 || den <= 0) frac = 0;
    else if (num >= den) frac = 65536;
    else frac = int'((longint'(num) * 65536) / den);
  endfunction

  function automatic longint reflectance(in_word_t w);
    int iv, is, fv, fs;
    longint t1, t2, wt [3], a, b, c, sum;
    t1 = longint'(w.azimuth_turns);
    t2 = (2 * t1) & 16'hffff;
    wt[0] = 32768;
    wt[1] = 2 * longint'(cos_table[(t1 * ROM_DEPTH) >> 16]);
    wt[2] = 2 * longint'(cos_table[(t2 * ROM_DEPTH) >> 16]);
    sum = 0;
    find_cell(int'(w.view_cosine), iv, fv);
    find_cell(int'(w.sun_cosine), is, fs);
    for (int m = 0; m < MODES; m++) begin
      if (w.use_ocean) begin
        a = blend(ocean_tab[m][iv][is], ocean_tab[m][iv + 1][is], fv);
        b = blend(ocean_tab[m][iv][is + 1], ocean_tab[m][iv + 1][is + 1], fv);
      end else begin
        a = blend(sky_tab[m][iv][is], sky_tab[m][iv + 1][is], fv);
        b = blend(sky_tab[m][iv][is + 1], sky_tab[m][iv + 1][is + 1], fv);
      end
      c = blend(a, b, fs);
      sum += wt[m] * c;
    end
    if (sum <= 0) return 0;
    sum = (sum + 16384) >>> 15;
    return (sum > 64'sh7fffffff) ? 64'sh7fffffff : sum;
  endfunction

  // Updates the predictor with one accepted word and queues any answer it causes.
  function automatic void predict_answer(in_word_t w);
    out_word_t o;
    longint r;
    int cell_idx, frac;
    case (w.opcode)
      OP_NODE_WR: node_cos[w.row_index] = w.write_value[15:0];
      OP_SKY_WR:
        if (w.mode_index < MODES) sky_tab[w.mode_index][w.row_index][w.col_index] = w.write_value;
      OP_OCEAN_WR:
        if (w.mode_index < MODES)
          ocean_tab[w.mode_index][w.row_index][w.col_index] = w.write_value;
      OP_TRANS_WR: trans_vec[w.row_index] = w.write_value;
      OP_REFL_Q: begin
        r = layer_on ? reflectance(w) : 64'sd0;
        o.result_value = r[31:0];
        o.result_kind = KIND_REFL;
        expected_answers.push_back(o);
      end
      OP_TRANS_Q: begin
        if (layer_on) begin
          find_cell(int'(w.view_cosine), cell_idx, frac);
          r = blend(trans_vec[cell_idx], trans_vec[cell_idx + 1], frac);
        end else begin
          r = longint'(Q24_ONE);
        end
        o.result_value = r[31:0];
        o.result_kind = KIND_TRANS;
        expected_answers.push_back(o);
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_valid <= 1'b1;
    query <= w;
    do @(posedge clk); while (query_stall);
    predict_answer(w);
  endtask

  function automatic in_word_t rand_word(logic [2:0] op);
    in_word_t w;
    w.opcode = op;
    w.mode_index = 2'($urandom_range(0, MODES - 1));
    w.row_index = 5'($urandom);
    w.col_index = 5'($urandom);
    w.write_value = $urandom;
    w.sun_cosine = 16'($urandom_range(0, 32768));
    w.view_cosine = 16'($urandom_range(0, 32768));
    w.azimuth_turns = 16'($urandom);
    w.use_ocean = 1'($urandom);
    return w;
  endfunction

  // Table values are mostly moderate so that answers land between zero and saturation.
  function automatic logic signed [31:0] rand_entry();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0200_0000;
  endfunction

  task automatic send_node(int idx, int v);
    in_word_t w;
    w = rand_word(OP_NODE_WR);
    w.row_index = 5'(idx);
    w.write_value[15:0] = 16'(v);
    send_word(w);
  endtask

  task automatic load_ascending_nodes();
    int top;
    top = ($urandom_range(0, 1) == 0) ? 32768 : $urandom_range(31500, 32768);
    for (int i = 0; i < NODES; i++) begin
      if (i == 0) send_node(i, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 900));
      else if (i < LIVE) send_node(i, i * 5000 + $urandom_range(1, 900));
      else send_node(i, top);
    end
  endtask

  task automatic wait_idle();
    query_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_layer(logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    layer_on = v;
  endtask

  task automatic test_fill_stores();
    in_word_t w;
    quiet = 1;
    load_ascending_nodes();
    for (int m = 0; m < MODES; m++)
      for (int r = 0; r <= LIVE; r++)
        for (int c = 0; c <= LIVE; c++) begin
          w = rand_word(OP_SKY_WR);
          w.mode_index = 2'(m);
          w.row_index = 5'(r);
          w.col_index = 5'(c);
          w.write_value = rand_entry();
          send_word(w);
          w.opcode = OP_OCEAN_WR;
          w.write_value = rand_entry();
          send_word(w);
        end
    for (int r = 0; r < NODES; r++) begin
      w = rand_word(OP_TRANS_WR);
      w.row_index = 5'(r);
      w.write_value = rand_entry();
      send_word(w);
    end
    quiet = 0;
  endtask

  task automatic test_layer_absent();
    in_word_t w;
    for (int i = 0; i < 6; i++) begin
      w = rand_word((i % 2 == 0) ? OP_REFL_Q : OP_TRANS_Q);
      send_word(w);
    end
  endtask

  task automatic test_directed();
    in_word_t w;
    logic [15:0] cos_edges [4] = '{16'd0, 16'd32768, 16'd16384, 16'd500};
    logic [15:0] turn_edges [4] = '{16'h0000, 16'hffff, 16'h4000, 16'h8000};
    for (int i = 0; i < 4; i++) begin
      w = rand_word(OP_REFL_Q);
      w.sun_cosine = cos_edges[i];
      w.view_cosine = cos_edges[3 - i];
      w.azimuth_turns = turn_edges[i];
      w.use_ocean = i[0];
      send_word(w);
      w.opcode = OP_TRANS_Q;
      send_word(w);
    end
    // Largest entries in the corner cell push the weighted sum into saturation.
    for (int m = 0; m < MODES; m++) begin
      w = rand_word(OP_SKY_WR);
      w.mode_index = 2'(m);
      w.row_index = '0;
      w.col_index = '0;
      w.write_value = 32'sh7fffffff;
      send_word(w);
    end
    w = rand_word(OP_REFL_Q);
    w.sun_cosine = '0;
    w.view_cosine = '0;
    w.azimuth_turns = '0;
    w.use_ocean = 1'b0;
    send_word(w);
    // Most negative entries drive the sum below zero and the answer clamps.
    for (int m = 0; m < MODES; m++) begin
      w = rand_word(OP_SKY_WR);
      w.mode_index = 2'(m);
      w.row_index = '0;
      w.col_index = '0;
      w.write_value = 32'sh80000000;
      send_word(w);
    end
    w = rand_word(OP_REFL_Q);
    w.sun_cosine = '0;
    w.view_cosine = '0;
    w.azimuth_turns = '0;
    w.use_ocean = 1'b0;
    send_word(w);
    // A negative transmission node is passed through unclamped.
    w = rand_word(OP_TRANS_WR);
    w.row_index = '0;
    w.write_value = 32'sh80000000;
    send_word(w);
    w = rand_word(OP_TRANS_Q);
    w.view_cosine = '0;
    send_word(w);
    // An out-of-range mode and the unused opcodes change nothing.
    w = rand_word(OP_OCEAN_WR);
    w.mode_index = 2'd3;
    send_word(w);
    send_word(rand_word(3'd6));
    send_word(rand_word(3'd7));
  endtask

  task automatic test_degenerate_nodes();
    in_word_t w;
    send_node(1, node_cos[0]);
    send_node(3, int'(node_cos[2]) - 300);
    send_node(NODES - 1, node_cos[NODES - 2]);
    for (int i = 0; i < 6; i++) begin
      w = rand_word(i % 2 == 0 ? OP_REFL_Q : OP_TRANS_Q);
      w.view_cosine = 16'((i < 2) ? int'(node_cos[0]) : $urandom_range(0, 4000));
      w.sun_cosine = 16'((i < 4) ? int'(node_cos[2]) : 32768);
      send_word(w);
    end
    load_ascending_nodes();
  endtask

  task automatic test_random_traffic();
    in_word_t w;
    int pick, idx;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) set_layer(1'b0);
      if (n == RANDOM_ITEMS / 3 + 40) set_layer(1'b1);
      quiet = (n >= RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 150);
      pick = $urandom_range(0, 99);
      if (pick < 40) w = rand_word(OP_REFL_Q);
      else if (pick < 60) w = rand_word(OP_TRANS_Q);
      else if (pick < 72) begin
        w = rand_word(OP_SKY_WR);
        w.write_value = rand_entry();
      end else if (pick < 84) begin
        w = rand_word(OP_OCEAN_WR);
        w.write_value = rand_entry();
      end else if (pick < 90) begin
        w = rand_word(OP_TRANS_WR);
        w.write_value = rand_entry();
      end else if (pick < 95) begin
        // Node rewrite that mostly keeps the order; otherwise it stays at or below the top.
        idx = $urandom_range(0, LIVE - 1);
        w = rand_word(OP_NODE_WR);
        w.row_index = 5'(idx);
        if (idx > 0 && $urandom_range(0, 3) != 0)
          w.write_value[15:0] = 16'($urandom_range(node_cos[idx - 1], node_cos[idx + 1]));
        else
          w.write_value[15:0] = 16'($urandom_range(0, node_cos[NODES - 1]));
      end else begin
        w = rand_word($urandom_range(0, 1) ? 3'd6 : 3'd7);
        if (pick == 99) begin
          w.opcode = OP_SKY_WR;
          w.mode_index = 2'd3;
        end
      end
      send_word(w);
    end
    quiet = 0;
  endtask

  // Answer side: random back-pressure per word, plus a quiet stretch.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      answer_stall <= 1'b0;
    end else begin
      if (answer_valid && !answer_stall) begin
        if (expected_answers.size() == 0) begin
          $error("answer with nothing expected: value %h kind %b",
                 answer.result_value, answer.result_kind);
          error_count++;
        end else begin
          if (answer.result_value !== expected_answers[0].result_value) begin
            $error("result_value expected %h actual %h",
                   expected_answers[0].result_value, answer.result_value);
            error_count++;
          end
          if (answer.result_kind !== expected_answers[0].result_kind) begin
            $error("result_kind expected %b actual %b",
                   expected_answers[0].result_kind, answer.result_kind);
            error_count++;
          end
          void'(expected_answers.pop_front());
        end
        stall_left = quiet ? 0 : $urandom_range(0, 3);
      end
      answer_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    error_count = 0;
    quiet = 0;
    layer_on = 1'b0;
    rst = 1'b1;
    query_valid = 1'b0;
    query = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    build_cosines();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_stores();
    test_layer_absent();
    set_layer(1'b1);
    test_directed();
    test_degenerate_nodes();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/fmti_pkg.sv
sv/fmti_store.sv
sv/fmti_cos_rom.sv
sv/fmti_lerp.sv
sv/fourier_mode_table_interpolator.sv
sim/tb_fourier_mode_table_interpolator.sv
